FILE: src/cbm_pkg.sv
// Shared types, constants and codes for the complex band-pass mix/FIR core.
// No dependencies; every other file imports this package.
package cbm_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int NTAP_W     = 6;
    localparam int TAP_IDX_W  = 6;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default tap count of the delay chain.
    localparam int MAX_TAPS_DEF = 64;

    // Shared complex MAC widths: 32x32 product and a guard-bit accumulator.
    localparam int MAC_PROD_W = 2 * PHASE_W;
    localparam int MAC_ACC_W  = MAC_PROD_W + 2;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_TAP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NTAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_RE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_IM = 2'd2;

    // Reset values.
    localparam logic [NTAP_W-1:0]         NTAP_RESET = 6'd63;
    localparam logic signed [PHASE_W-1:0] ONE_Q30    = 32'sh4000_0000;

    // One complex delay entry.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx16_t;

    // Control broadcast to every cell of the delay chain.
    typedef struct packed {
        logic                        shift;
        logic                        rotate;
        logic                        clear;
        logic                        tap_we;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0]  tap_value;
    } cell_ctl_t;

    // Control of the shared complex MAC.
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic neg;
    } mac_ctl_t;

    // Main sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_SHIFT,
        S_FIR,
        S_FIR_DRAIN,
        S_YRND,
        S_DONE
    } state_t;

    // Sub-phase of one MAC micro-operation.
    typedef enum logic [1:0] {
        PH_MUL,
        PH_ACC,
        PH_WB
    } mac_ph_t;

    // MAC micro-operations, named by their operand pair.
    typedef enum logic [3:0] {
        U_PR_IR,
        U_PI_II,
        U_PR_II,
        U_PI_IR,
        U_XR_PR,
        U_XI_PI,
        U_XR_PI,
        U_XI_PR,
        U_YR_PR,
        U_YI_PI,
        U_YI_PR,
        U_YR_PI
    } uop_t;

endpackage

FILE: src/cbm_req_if.sv
// Input item channel: valid/ready handshake with the request payload.
// Depends on cbm_pkg for field widths.
interface cbm_req_if
    import cbm_pkg::*;
    ;
    logic                        valid;
    logic                        ready;
    logic [FUNC_W-1:0]           func;
    logic signed [SAMPLE_W-1:0]  sample_re;
    logic signed [SAMPLE_W-1:0]  sample_im;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [SAMPLE_W-1:0]  tap_value;
    logic                        end_of_block;

    modport source (
        output valid, func, sample_re, sample_im, tap_index, tap_value, end_of_block,
        input  ready
    );

    modport sink (
        input  valid, func, sample_re, sample_im, tap_index, tap_value, end_of_block,
        output ready
    );
endinterface

FILE: src/cbm_rsp_if.sv
// Result item channel: valid/ready handshake with the filtered sample.
// Depends on cbm_pkg for field widths.
interface cbm_rsp_if
    import cbm_pkg::*;
    ;
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  out_re;
    logic signed [SAMPLE_W-1:0]  out_im;
    logic                        saturated;
    logic                        last_out;

    modport source (
        output valid, out_re, out_im, saturated, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, saturated, last_out,
        output ready
    );
endinterface

FILE: src/complex_bandpass_mix_fir_core.sv
// Complex band-pass core: phase advance, mix down, real-tap FIR, mix up.
// A sample item gives its result after the walk of all MAX_TAPS cells past the FIR MAC
// and twelve micro-operations of the one shared 32x32 MAC; the next item is taken
// only once that result has been loaded into the output register.
// Tap load, clear and unused items give no result.
// Reset (rst_n, async, active low) zeroes delay line and taps, sets phase to 1+0j.
module complex_bandpass_mix_fir_core
    import cbm_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    cbm_req_if.sink                req,
    cbm_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_TAPS);
    localparam int CMP_W = (CNT_W > NTAP_W) ? CNT_W : NTAP_W;
    localparam int ACC_W = 2 * SAMPLE_W + $clog2(MAX_TAPS);
    localparam int Y_W   = ACC_W - (SAMPLE_W - 2);
    localparam logic signed [ACC_W:0] FIR_HALF = (ACC_W + 1)'(1) <<< (SAMPLE_W - 2);

    // Configuration registers.
    logic [NTAP_W-1:0]          ntap_reg;
    logic signed [PHASE_W-1:0]  inc_re_reg;
    logic signed [PHASE_W-1:0]  inc_im_reg;

    // Sequencer.
    state_t   state_reg, state_next;
    uop_t     uop_reg, uop_next;
    mac_ph_t  ph_reg, ph_next;

    // Datapath registers.
    logic signed [PHASE_W-1:0]   phase_re_reg;
    logic signed [PHASE_W-1:0]   phase_im_reg;
    logic signed [PHASE_W-1:0]   npr_reg;
    logic signed [SAMPLE_W-1:0]  x_re_reg;
    logic signed [SAMPLE_W-1:0]  x_im_reg;
    logic                        last_reg;
    logic signed [SAMPLE_W-1:0]  br_reg;
    logic signed [SAMPLE_W-1:0]  bi_reg;
    logic [CNT_W-1:0]            fir_cnt_reg;
    logic                        fv_reg;
    logic signed [2*SAMPLE_W-1:0] fprod_re_reg;
    logic signed [2*SAMPLE_W-1:0] fprod_im_reg;
    logic signed [ACC_W-1:0]     fir_acc_re_reg;
    logic signed [ACC_W-1:0]     fir_acc_im_reg;
    logic signed [Y_W-1:0]       y_re_reg;
    logic signed [Y_W-1:0]       y_im_reg;
    logic signed [SAMPLE_W-1:0]  ore_reg;
    logic signed [SAMPLE_W-1:0]  oim_reg;
    logic                        sat_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_re_reg;
    logic signed [SAMPLE_W-1:0]  out_im_reg;
    logic                        out_sat_reg;
    logic                        out_last_reg;

    logic                        in_acc;
    logic                        out_free;
    logic                        fv_next;
    logic signed [ACC_W:0]       y_sum_re;
    logic signed [ACC_W:0]       y_sum_im;
    logic signed [ACC_W:0]       y_shr_re;
    logic signed [ACC_W:0]       y_shr_im;

    // Shared MAC.
    mac_ctl_t                    mac_ctl;
    logic signed [PHASE_W-1:0]   mac_a;
    logic signed [PHASE_W-1:0]   mac_b;
    logic signed [PHASE_W-1:0]   mac_q32;
    logic signed [SAMPLE_W-1:0]  mac_q16;
    logic                        mac_sat16;

    // Delay chain.
    cell_ctl_t                   cell_ctl;
    cplx16_t                     new_entry;
    cplx16_t                     cell_d [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]  cell_t [MAX_TAPS];

    assign in_acc   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntap_reg   <= NTAP_RESET;
            inc_re_reg <= ONE_Q30;
            inc_im_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NTAP:   ntap_reg   <= cfg_wdata[NTAP_W-1:0];
                CFG_INC_RE: inc_re_reg <= cfg_wdata;
                CFG_INC_IM: inc_im_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            uop_reg   <= U_PR_IR;
            ph_reg    <= PH_MUL;
        end
        else
        begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
            ph_reg    <= ph_next;
        end
    end

    // Next state, MAC control and input ready.
    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        ph_next    = ph_reg;
        mac_ctl    = '0;
        req.ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && req.func == FUNC_SAMPLE)
                begin
                    state_next = S_MIX;
                    uop_next   = U_PR_IR;
                    ph_next    = PH_MUL;
                end
            end
            S_MIX:
            begin
                case (ph_reg)
                    PH_MUL:
                    begin
                        mac_ctl.mul_en = 1'b1;
                        ph_next        = PH_ACC;
                    end
                    PH_ACC:
                    begin
                        mac_ctl.acc_en = 1'b1;
                        mac_ctl.first  = !uop_reg[0];
                        mac_ctl.neg    = (uop_reg == U_PI_II) || (uop_reg == U_XI_PI) ||
                                         (uop_reg == U_YR_PI);
                        if (uop_reg[0])
                        begin
                            ph_next = PH_WB;
                        end
                        else
                        begin
                            ph_next  = PH_MUL;
                            uop_next = uop_t'(uop_reg + 4'd1);
                        end
                    end
                    default:
                    begin
                        ph_next  = PH_MUL;
                        uop_next = uop_t'(uop_reg + 4'd1);
                        if (uop_reg == U_XI_PR)
                        begin
                            state_next = S_SHIFT;
                        end
                        else if (uop_reg == U_YR_PI)
                        begin
                            state_next = S_DONE;
                            uop_next   = U_PR_IR;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                state_next = S_FIR;
            end
            S_FIR:
            begin
                if (fir_cnt_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    state_next = S_FIR_DRAIN;
                end
            end
            S_FIR_DRAIN:
            begin
                state_next = S_YRND;
            end
            S_YRND:
            begin
                state_next = S_MIX;
                uop_next   = U_YR_PR;
                ph_next    = PH_MUL;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // MAC operand selection per micro-operation.
    always_comb
    begin
        case (uop_reg)
            U_PR_IR: begin mac_a = phase_re_reg;         mac_b = inc_re_reg;   end
            U_PI_II: begin mac_a = phase_im_reg;         mac_b = inc_im_reg;   end
            U_PR_II: begin mac_a = phase_re_reg;         mac_b = inc_im_reg;   end
            U_PI_IR: begin mac_a = phase_im_reg;         mac_b = inc_re_reg;   end
            U_XR_PR: begin mac_a = PHASE_W'(x_re_reg);   mac_b = phase_re_reg; end
            U_XI_PI: begin mac_a = PHASE_W'(x_im_reg);   mac_b = phase_im_reg; end
            U_XR_PI: begin mac_a = PHASE_W'(x_re_reg);   mac_b = phase_im_reg; end
            U_XI_PR: begin mac_a = PHASE_W'(x_im_reg);   mac_b = phase_re_reg; end
            U_YR_PR: begin mac_a = PHASE_W'(y_re_reg);   mac_b = phase_re_reg; end
            U_YI_PI: begin mac_a = PHASE_W'(y_im_reg);   mac_b = phase_im_reg; end
            U_YI_PR: begin mac_a = PHASE_W'(y_im_reg);   mac_b = phase_re_reg; end
            U_YR_PI: begin mac_a = PHASE_W'(y_re_reg);   mac_b = phase_im_reg; end
            default: begin mac_a = '0;                   mac_b = '0;           end
        endcase
    end

    cbm_cmac u_cmac (
        .clk   (clk),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .q32   (mac_q32),
        .q16   (mac_q16),
        .sat16 (mac_sat16)
    );

    // Phase register: advanced during a sample, reset to 1+0j by a clear item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_re_reg <= ONE_Q30;
            phase_im_reg <= '0;
        end
        else if (in_acc && req.func == FUNC_CLEAR)
        begin
            phase_re_reg <= ONE_Q30;
            phase_im_reg <= '0;
        end
        else if (state_reg == S_MIX && ph_reg == PH_WB && uop_reg == U_PI_IR)
        begin
            phase_re_reg <= npr_reg;
            phase_im_reg <= mac_q32;
        end
    end

    // Write-back of rounded MAC results and capture of the sample.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_re_reg <= req.sample_re;
            x_im_reg <= req.sample_im;
            last_reg <= req.end_of_block;
        end
        if (state_reg == S_MIX && ph_reg == PH_WB)
        begin
            case (uop_reg)
                U_PI_II: npr_reg <= mac_q32;
                U_XI_PI: br_reg  <= mac_q16;
                U_XI_PR: bi_reg  <= mac_q16;
                U_YI_PI:
                begin
                    ore_reg <= mac_q16;
                    sat_reg <= mac_sat16;
                end
                U_YR_PI:
                begin
                    oim_reg <= mac_q16;
                    sat_reg <= sat_reg | mac_sat16;
                end
                default: ;
            endcase
        end
    end

    // Chain control: clear and tap load at acceptance, shift, then a full rotation.
    assign new_entry.re = br_reg;
    assign new_entry.im = bi_reg;

    always_comb
    begin
        cell_ctl           = '0;
        cell_ctl.clear     = in_acc && req.func == FUNC_CLEAR;
        cell_ctl.tap_we    = in_acc && req.func == FUNC_LOAD_TAP;
        cell_ctl.tap_index = req.tap_index;
        cell_ctl.tap_value = req.tap_value;
        cell_ctl.shift     = state_reg == S_SHIFT;
        cell_ctl.rotate    = state_reg == S_FIR;
    end

    // Row of cells; cell 0 is the head that feeds the FIR MAC.
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % MAX_TAPS;
        cplx16_t shift_src;

        if (k == 0)
        begin : g_head
            assign shift_src = new_entry;
        end
        else
        begin : g_body
            assign shift_src = cell_d[k-1];
        end

        cbm_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .shift_in (shift_src),
            .rot_d_in (cell_d[NXT]),
            .rot_t_in (cell_t[NXT]),
            .d        (cell_d[k]),
            .tap      (cell_t[k])
        );
    end

    // FIR walk: the product at the head counts only for the first ntap steps.
    assign fv_next = (state_reg == S_FIR) && (CMP_W'(fir_cnt_reg) < CMP_W'(ntap_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fprod_re_reg <= (2*SAMPLE_W)'(cell_t[0]) * (2*SAMPLE_W)'(cell_d[0].re);
        fprod_im_reg <= (2*SAMPLE_W)'(cell_t[0]) * (2*SAMPLE_W)'(cell_d[0].im);

        if (state_reg == S_SHIFT)
        begin
            fir_cnt_reg    <= '0;
            fir_acc_re_reg <= '0;
            fir_acc_im_reg <= '0;
        end
        else
        begin
            if (state_reg == S_FIR)
            begin
                fir_cnt_reg <= fir_cnt_reg + CNT_W'(1);
            end
            if (fv_reg)
            begin
                fir_acc_re_reg <= fir_acc_re_reg + ACC_W'(fprod_re_reg);
                fir_acc_im_reg <= fir_acc_im_reg + ACC_W'(fprod_im_reg);
            end
        end

        if (state_reg == S_YRND)
        begin
            y_re_reg <= y_shr_re[Y_W-1:0];
            y_im_reg <= y_shr_im[Y_W-1:0];
        end
    end

    // FIR sum rounded half up from Q.30 to Q.15.
    assign y_sum_re = (ACC_W + 1)'(fir_acc_re_reg) + FIR_HALF;
    assign y_sum_im = (ACC_W + 1)'(fir_acc_im_reg) + FIR_HALF;
    assign y_shr_re = y_sum_re >>> (SAMPLE_W - 1);
    assign y_shr_im = y_sum_im >>> (SAMPLE_W - 1);

    // Output register: loaded at the end of a sample, held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_re_reg   <= ore_reg;
            out_im_reg   <= oim_reg;
            out_sat_reg  <= sat_reg;
            out_last_reg <= last_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_re    = out_re_reg;
    assign rsp.out_im    = out_im_reg;
    assign rsp.saturated = out_sat_reg;
    assign rsp.last_out  = out_last_reg;

    // A finished sample always lands in the output register and frees the input.
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished sample not loaded into output register");

    // An accepted sample starts the MAC sequence at the phase update.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req.func == FUNC_SAMPLE) |=>
        (state_reg == S_MIX && uop_reg == U_PR_IR && ph_reg == PH_MUL))
        else $error("sample item did not start the phase update");

    // The FIR accumulators start from zero after the new entry shifts in.
    a_acc_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |=> (fir_acc_re_reg == '0 && fir_acc_im_reg == '0))
        else $error("FIR accumulator not cleared");

    // The walk rotates the chain exactly once around, so entries return home.
    a_fir_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIR_DRAIN) |-> ($past(state_reg, MAX_TAPS + 1) == S_SHIFT))
        else $error("FIR walk length differs from chain length");

endmodule

FILE: src/cbm_cell.sv
// One cell of the delay chain: holds a complex delay entry and its tap.
// Depends on cbm_pkg for the entry type and the chain control struct.
module cbm_cell
    import cbm_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctl_t                   ctl,
    input  cplx16_t                     shift_in,
    input  cplx16_t                     rot_d_in,
    input  logic signed [SAMPLE_W-1:0]  rot_t_in,
    output cplx16_t                     d,
    output logic signed [SAMPLE_W-1:0]  tap
);

    cplx16_t                     d_reg;
    logic signed [SAMPLE_W-1:0]  tap_reg;
    logic                        tap_hit;

    // A tap load only lands in the cell whose position matches the index.
    assign tap_hit = ctl.tap_we && (int'(ctl.tap_index) == CELL_IDX);

    // Delay entry: clear, shift in a new sample, or rotate toward the head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (ctl.clear)
        begin
            d_reg <= '0;
        end
        else if (ctl.shift)
        begin
            d_reg <= shift_in;
        end
        else if (ctl.rotate)
        begin
            d_reg <= rot_d_in;
        end
    end

    // Tap word: loaded by index, and rotated along with the delay entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (tap_hit)
        begin
            tap_reg <= ctl.tap_value;
        end
        else if (ctl.rotate)
        begin
            tap_reg <= rot_t_in;
        end
    end

    assign d   = d_reg;
    assign tap = tap_reg;

endmodule

FILE: src/cbm_cmac.sv
// Shared 32x32 multiply-accumulate with Q.30 round half up and clipping.
// Depends on cbm_pkg for widths and the MAC control struct.
module cbm_cmac
    import cbm_pkg::*;
(
    input  logic                        clk,
    input  mac_ctl_t                    ctl,
    input  logic signed [PHASE_W-1:0]   a,
    input  logic signed [PHASE_W-1:0]   b,
    output logic signed [PHASE_W-1:0]   q32,
    output logic signed [SAMPLE_W-1:0]  q16,
    output logic                        sat16
);

    localparam logic signed [MAC_ACC_W-1:0] HALF  = MAC_ACC_W'(1) <<< 29;
    localparam logic signed [MAC_ACC_W-1:0] MAX32 = MAC_ACC_W'(64'sd2147483647);
    localparam logic signed [MAC_ACC_W-1:0] MIN32 = MAC_ACC_W'(-64'sd2147483648);
    localparam logic signed [MAC_ACC_W-1:0] MAX16 = MAC_ACC_W'(64'sd32767);
    localparam logic signed [MAC_ACC_W-1:0] MIN16 = MAC_ACC_W'(-64'sd32768);

    logic signed [MAC_PROD_W-1:0] prod_reg;
    logic signed [MAC_ACC_W-1:0]  acc_reg;
    logic signed [MAC_ACC_W-1:0]  prod_ext;
    logic signed [MAC_ACC_W-1:0]  acc_base;
    logic signed [MAC_ACC_W-1:0]  rnd_sum;
    logic signed [MAC_ACC_W-1:0]  rnd;

    assign prod_ext = MAC_ACC_W'(prod_reg);
    assign acc_base = ctl.first ? '0 : acc_reg;

    // Multiply stage, then accumulate stage in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a * b;
        end
        if (ctl.acc_en)
        begin
            acc_reg <= ctl.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
        end
    end

    // Round half up to Q.0 of a Q.30 sum, then clip to 32 or 16 bits.
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        rnd     = rnd_sum >>> 30;

        if (rnd > MAX32)
        begin
            q32 = 32'sh7fff_ffff;
        end
        else if (rnd < MIN32)
        begin
            q32 = 32'sh8000_0000;
        end
        else
        begin
            q32 = rnd[PHASE_W-1:0];
        end

        sat16 = 1'b0;
        if (rnd > MAX16)
        begin
            q16   = 16'sh7fff;
            sat16 = 1'b1;
        end
        else if (rnd < MIN16)
        begin
            q16   = 16'sh8000;
            sat16 = 1'b1;
        end
        else
        begin
            q16 = rnd[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: dv/complex_bandpass_mix_fir_core_tb.sv
// Self-checking testbench for complex_bandpass_mix_fir_core: directed items,
// then random phases, each result checked against a table value or a bit-exact predictor.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if and the core itself.
module complex_bandpass_mix_fir_core_tb;
    import cbm_pkg::*;

    localparam int N_TAPS          = MAX_TAPS_DEF;
    localparam int LATENCY         = N_TAPS + 34;
    localparam int SETTLE_CYCLES   = LATENCY + 12;
    localparam int HOLD_CYCLES     = 600;
    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int WIDE_W          = 80;

    // The fourth function code has no meaning in the core and must be ignored.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       sat;
        logic                       last;
    } filt_out_t;

    // How the result of a stimulus row is known.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_VALUE
    } row_check_t;

    typedef struct {
        logic [FUNC_W-1:0]          func;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [TAP_IDX_W-1:0]       tap_index;
        logic signed [SAMPLE_W-1:0] tap_value;
        logic                       eob;
        row_check_t                 chk;
        filt_out_t                  want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cbm_req_if req_ch ();
    cbm_rsp_if rsp_ch ();

    complex_bandpass_mix_fir_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: configuration, delay line, taps and phase register.
    logic [NTAP_W-1:0]          ntap_cfg;
    logic signed [PHASE_W-1:0]  inc_re_cfg;
    logic signed [PHASE_W-1:0]  inc_im_cfg;
    logic signed [PHASE_W-1:0]  phase_re;
    logic signed [PHASE_W-1:0]  phase_im;
    cplx16_t                    dly [N_TAPS];
    logic signed [SAMPLE_W-1:0] taps [N_TAPS];

    filt_out_t filt_q [$];
    stim_row_t dir_table [$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_rx;
    int  errors;
    int  n_samples;
    int  n_loads;
    int  n_clears;
    int  n_unused;
    int  n_results;
    int  n_sat;
    int  n_holds;
    int  quiet_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Round half up: add half an LSB, then floor.
    function automatic wide_t round_q(input wide_t v, input int sh);
        return (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic wide_t clamp(input wide_t v, input int bits, output bit hit);
        wide_t hi;
        wide_t lo;
        hi  = (wide_t'(1) <<< (bits - 1)) - 1;
        lo  = -hi - 1;
        hit = 1'b0;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void reset_filter();
        ntap_cfg   = NTAP_RESET;
        inc_re_cfg = ONE_Q30;
        inc_im_cfg = '0;
        phase_re   = ONE_Q30;
        phase_im   = '0;
        for (int k = 0; k < N_TAPS; k++)
        begin
            dly[k]  = '0;
            taps[k] = '0;
        end
    endfunction

    // Applies one accepted item to the filter state; returns 1 with the filtered
    // sample when the item produces a result.
    function automatic bit filter_step(input stim_row_t it, output filt_out_t res);
        wide_t pr, pi, ir, ii, npr, npi, xr, xi, br, bi;
        wide_t acc_r, acc_i, yr, yi, o_r, o_i;
        bit    dummy, hit_r, hit_i;
        int    n;
        res = '0;
        case (it.func)
            FUNC_LOAD_TAP:
            begin
                if (int'(it.tap_index) < N_TAPS)
                    taps[it.tap_index] = it.tap_value;
                return 1'b0;
            end
            FUNC_CLEAR:
            begin
                for (int k = 0; k < N_TAPS; k++)
                    dly[k] = '0;
                phase_re = ONE_Q30;
                phase_im = '0;
                return 1'b0;
            end
            FUNC_SAMPLE:
            begin
                // Advance the phase by one rotation step.
                pr  = phase_re;
                pi  = phase_im;
                ir  = inc_re_cfg;
                ii  = inc_im_cfg;
                npr = clamp(round_q(pr * ir - pi * ii, 30), PHASE_W, dummy);
                npi = clamp(round_q(pr * ii + pi * ir, 30), PHASE_W, dummy);
                phase_re = npr[PHASE_W-1:0];
                phase_im = npi[PHASE_W-1:0];

                // Mix down and shift into the delay line.
                xr = it.re;
                xi = it.im;
                br = clamp(round_q(xr * npr - xi * npi, 30), SAMPLE_W, dummy);
                bi = clamp(round_q(xr * npi + xi * npr, 30), SAMPLE_W, dummy);
                for (int k = N_TAPS - 1; k >= 1; k--)
                    dly[k] = dly[k-1];
                dly[0].re = br[SAMPLE_W-1:0];
                dly[0].im = bi[SAMPLE_W-1:0];

                // Real-tap FIR over the taps in use.
                n = (int'(ntap_cfg) > N_TAPS) ? N_TAPS : int'(ntap_cfg);
                acc_r = '0;
                acc_i = '0;
                for (int k = 0; k < n; k++)
                begin
                    acc_r += wide_t'(taps[k]) * wide_t'(dly[k].re);
                    acc_i += wide_t'(taps[k]) * wide_t'(dly[k].im);
                end
                yr = round_q(acc_r, 15);
                yi = round_q(acc_i, 15);

                // Mix back up with the conjugate phase.
                o_r = clamp(round_q(yr * npr + yi * npi, 30), SAMPLE_W, hit_r);
                o_i = clamp(round_q(yi * npr - yr * npi, 30), SAMPLE_W, hit_i);
                res.re   = o_r[SAMPLE_W-1:0];
                res.im   = o_i[SAMPLE_W-1:0];
                res.sat  = hit_r | hit_i;
                res.last = it.eob;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic stim_row_t dir_row(
        input logic [FUNC_W-1:0] func, input int re, input int im, input int idx,
        input int val, input bit eob, input row_check_t chk,
        input int w_re = 0, input int w_im = 0, input bit w_sat = 1'b0);
        stim_row_t r;
        r.func      = func;
        r.re        = SAMPLE_W'(re);
        r.im        = SAMPLE_W'(im);
        r.tap_index = TAP_IDX_W'(idx);
        r.tap_value = SAMPLE_W'(val);
        r.eob       = eob;
        r.chk       = chk;
        r.want.re   = SAMPLE_W'(w_re);
        r.want.im   = SAMPLE_W'(w_im);
        r.want.sat  = w_sat;
        r.want.last = eob;
        return r;
    endfunction

    // Offers one item, waits for it to be taken and records its expected result.
    task automatic send(input stim_row_t it);
        filt_out_t pred;
        bit        has_result;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= it.func;
        req_ch.sample_re    <= it.re;
        req_ch.sample_im    <= it.im;
        req_ch.tap_index    <= it.tap_index;
        req_ch.tap_value    <= it.tap_value;
        req_ch.end_of_block <= it.eob;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);

        has_result = filter_step(it, pred);
        if (it.chk == CHK_VALUE)
            filt_q.push_back(it.want);
        else if (it.chk == CHK_MODEL && has_result)
            filt_q.push_back(pred);

        case (it.func)
            FUNC_SAMPLE:   n_samples++;
            FUNC_LOAD_TAP: n_loads++;
            FUNC_CLEAR:    n_clears++;
            default:       n_unused++;
        endcase
    endtask

    // Registers change only once the core has drained every item.
    task automatic program_regs(input logic [NTAP_W-1:0] ntap,
                                input logic [PHASE_W-1:0] inc_re_v,
                                input logic [PHASE_W-1:0] inc_im_v);
        while (filt_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NTAP;
        cfg_wdata <= {(CFG_DATA_W - NTAP_W)'($urandom), ntap};
        @(posedge clk);
        cfg_index <= CFG_INC_RE;
        cfg_wdata <= inc_re_v;
        @(posedge clk);
        cfg_index <= CFG_INC_IM;
        cfg_wdata <= inc_im_v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        ntap_cfg   = ntap;
        inc_re_cfg = inc_re_v;
        inc_im_cfg = inc_im_v;
    endtask

    // One random phase under one register setting and one idling pattern.
    task automatic run_phase(input logic [NTAP_W-1:0] ntap, input logic [PHASE_W-1:0] ire,
                             input logic [PHASE_W-1:0] iim, input int tx, input int rx,
                             input bit stall);
        stim_row_t it;
        int        done_items;
        int        roll;
        program_regs(ntap, ire, iim);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        if (stall)
            hold_rx = 1'b1;
        done_items = 0;
        while (done_items < ITEMS_PER_PHASE)
        begin
            roll = $urandom_range(99);
            it.func = (roll < 70) ? FUNC_SAMPLE :
                      (roll < 85) ? FUNC_LOAD_TAP :
                      (roll < 92) ? FUNC_CLEAR : FUNC_UNUSED;
            it.re        = SAMPLE_W'($urandom);
            it.im        = SAMPLE_W'($urandom);
            it.tap_index = TAP_IDX_W'($urandom);
            it.eob       = 1'($urandom_range(1));
            it.chk       = CHK_MODEL;
            it.want      = '0;
            // Full-scale samples now and then.
            if ($urandom_range(9) == 0)
                it.re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            if ($urandom_range(9) == 0)
                it.im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            // Mostly small taps so that many results stay clear of clipping.
            if ($urandom_range(3) == 0)
                it.tap_value = SAMPLE_W'($urandom);
            else
                it.tap_value = SAMPLE_W'(int'($urandom_range(4095)) - 2048);
            send(it);
            if (it.func != FUNC_UNUSED)
                done_items++;
        end
        req_ch.valid <= 1'b0;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        filt_out_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            if (rsp_ch.saturated === 1'b1)
                n_sat++;
            if (filt_q.size() == 0)
            begin
                $error("unexpected result: out_re %0d out_im %0d",
                       rsp_ch.out_re, rsp_ch.out_im);
                errors++;
            end
            else
            begin
                want = filt_q.pop_front();
                if (rsp_ch.out_re !== want.re)
                begin
                    $error("out_re: expected %0d, got %0d", want.re, rsp_ch.out_re);
                    errors++;
                end
                if (rsp_ch.out_im !== want.im)
                begin
                    $error("out_im: expected %0d, got %0d", want.im, rsp_ch.out_im);
                    errors++;
                end
                if (rsp_ch.saturated !== want.sat)
                begin
                    $error("saturated: expected %0d, got %0d", want.sat, rsp_ch.saturated);
                    errors++;
                end
                if (rsp_ch.last_out !== want.last)
                begin
                    $error("last_out: expected %0d, got %0d", want.last, rsp_ch.last_out);
                    errors++;
                end
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold when asked.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
                n_holds++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run when no item moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_NTAP;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_SAMPLE;
        req_ch.sample_re    <= '0;
        req_ch.sample_im    <= '0;
        req_ch.tap_index    <= '0;
        req_ch.tap_value    <= '0;
        req_ch.end_of_block <= 1'b0;
        hold_rx      = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 35;
        rx_idle_pct  = 66;
        reset_filter();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: unit phase, 63 taps, all taps zero.
        dir_table.push_back(dir_row(FUNC_SAMPLE, 32767, -32768, 0, 0, 1'b1, CHK_VALUE));
        dir_table.push_back(dir_row(FUNC_SAMPLE, -32768, 32767, 0, 0, 1'b0, CHK_VALUE));
        dir_table.push_back(dir_row(FUNC_UNUSED, -1, -1, 63, -1, 1'b1, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_LOAD_TAP, 0, 0, 0, 32767, 1'b0, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_LOAD_TAP, 0, 0, 63, -32768, 1'b1, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_LOAD_TAP, 0, 0, 1, -32768, 1'b0, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 32767, 32767, 0, 0, 1'b1, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_SAMPLE, -32768, -32768, 0, 0, 1'b0, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 0, 0, 0, 0, 1'b0, CHK_MODEL));
        // Clear keeps the taps but empties the delay line.
        dir_table.push_back(dir_row(FUNC_CLEAR, 5, 5, 5, 5, 1'b1, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_LOAD_TAP, 0, 0, 0, -32768, 1'b0, CHK_NONE));
        // Two full-scale negative taps drive the sum past both rails.
        dir_table.push_back(dir_row(FUNC_SAMPLE, -32768, -32768, 0, 0, 1'b0, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_SAMPLE, -32768, -32768, 0, 0, 1'b1, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 32767, 32767, 0, 0, 1'b0, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 32767, 32767, 0, 0, 1'b0, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_CLEAR, 0, 0, 0, 0, 1'b0, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 1, -1, 0, 0, 1'b1, CHK_MODEL));
        dir_table.push_back(dir_row(FUNC_LOAD_TAP, 0, 0, 42, 21845, 1'b0, CHK_NONE));
        dir_table.push_back(dir_row(FUNC_SAMPLE, 12345, -12345, 0, 0, 1'b0, CHK_MODEL));
        foreach (dir_table[i])
            send(dir_table[i]);
        req_ch.valid <= 1'b0;

        // Random phases; idling moves from slow receiver to slow sender to none.
        run_phase(6'd63, 32'sd992008094, -32'sd410903207, 35, 66, 1'b0);
        run_phase(6'd0, 32'sh8000_0000, 32'sh7fff_ffff, 35, 66, 1'b0);
        run_phase(6'd1, 32'sh7fff_ffff, 32'sh8000_0000, 35, 66, 1'b0);
        run_phase(6'd32, 32'sd0, ONE_Q30, 66, 35, 1'b0);
        run_phase(NTAP_W'($urandom_range(63, 1)), 32'($urandom), 32'($urandom), 66, 35, 1'b0);
        run_phase(6'd31, 32'sd1068571464, -32'sd105245103, 0, 0, 1'b1);
        run_phase(NTAP_RESET, ONE_Q30, 32'sd0, 0, 0, 1'b0);

        // Drain, then give the core time to settle.
        while (filt_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (filt_q.size() != 0)
            errors++;

        $display("Sent %0d samples, %0d tap loads, %0d clears, %0d unused items.",
                 n_samples, n_loads, n_clears, n_unused);
        $display("Checked %0d results (%0d clipped) over 8 settings, %0d long receiver holds.",
                 n_results, n_sat, n_holds);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/cbm_pkg.sv
src/cbm_req_if.sv
src/cbm_rsp_if.sv
src/cbm_cell.sv
src/cbm_cmac.sv
src/complex_bandpass_mix_fir_core.sv
dv/complex_bandpass_mix_fir_core_tb.sv
